/* design/sapp_pkg.sv */
// ----------------------------------------------------------------------------
// sapp_pkg: shared types and constants of the stereo point projection
// Widths, register indexes, reset values, stage payload structs and the
// rounding/saturation helper used on the screen coordinates.
// ----------------------------------------------------------------------------
package sapp_pkg;

  localparam int COORD_BITS    = 16;
  localparam int MAX_DISPARITY = 70;
  localparam int FRAC_BITS     = 14;
  localparam int ANGLE_W       = 16;
  localparam int OFFS_W        = 13;
  localparam int OUT_W         = 18;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int NUM_STAGES    = 7;

  // Arithmetic widths along the pipeline.
  localparam int PROD_W  = COORD_BITS + ANGLE_W;   // coordinate times angle
  localparam int ROT1_W  = PROD_W + 1;             // y1, z1 in Q.14
  localparam int MUL2_W  = ROT1_W + ANGLE_W;       // z1 times angle, Q.28
  localparam int Q28_W   = MUL2_W + 1;             // Y rotation sums, Q.28
  localparam int ROT2_W  = Q28_W - FRAC_BITS;      // x2, z2 in Q.14
  localparam int VSUM_W  = ROT2_W + 1;             // z2 plus eye distance
  localparam int SUM_W   = ROT2_W + 2;             // screen sums in Q.14
  localparam int OFF_W   = OFFS_W + 2;             // disparity plus offset

  // Disparity: trunc((z2 + 1000*2^14) / (5*2^14)), clamped.
  localparam int DISP_DIVISOR = 5;
  localparam int DISP_LIM     = (MAX_DISPARITY + 1) * DISP_DIVISOR;
  localparam int MAG_W        = $clog2(DISP_LIM);
  localparam int DISP_MAG_W   = $clog2(MAX_DISPARITY + 1);
  localparam int DISP_W       = DISP_MAG_W + 1;
  localparam int RECIP_SHIFT  = 18;
  localparam logic [15:0] RECIP_5 = 16'd52429;     // ceil(2^18 / 5)
  localparam logic signed [VSUM_W-1:0] EYE_DIST_Q14 = VSUM_W'(1000 * (2 ** FRAC_BITS));

  localparam int OUT_MAX = (2 ** (OUT_W - 1)) - 1;
  localparam int OUT_MIN = -(2 ** (OUT_W - 1));

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIN_X       = 3'd0,
    CFG_COS_X       = 3'd1,
    CFG_SIN_Y       = 3'd2,
    CFG_COS_Y       = 3'd3,
    CFG_HALF_WIDTH  = 3'd4,
    CFG_HALF_HEIGHT = 3'd5
  } cfg_idx_e;

  localparam logic signed [ANGLE_W-1:0] SIN_RST    = 16'sd0;
  localparam logic signed [ANGLE_W-1:0] COS_RST    = 16'sd16384;
  localparam logic [OFFS_W-1:0]         HALF_W_RST = 13'd400;
  localparam logic [OFFS_W-1:0]         HALF_H_RST = 13'd300;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] sin_x;
    logic signed [ANGLE_W-1:0] cos_x;
    logic signed [ANGLE_W-1:0] sin_y;
    logic signed [ANGLE_W-1:0] cos_y;
    logic [OFFS_W-1:0]         half_w;
    logic [OFFS_W-1:0]         half_h;
  } cfg_t;

  typedef struct packed {
    logic signed [ROT2_W-1:0] x2;
    logic signed [ROT2_W-1:0] z2;
    logic signed [ROT1_W-1:0] y1;
  } rot_t;

  typedef struct packed {
    logic signed [ROT2_W-1:0] x2;
    logic signed [ROT1_W-1:0] y1;
    logic signed [DISP_W-1:0] disp;
  } disp_t;

  // Divide a Q.14 value by 2^14 rounding toward zero, then saturate.
  function automatic logic signed [OUT_W-1:0] trunc_sat(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-FRAC_BITS-1:0] q;
    logic signed [SUM_W-FRAC_BITS:0]   r;
    logic                              fix;
    q   = $signed(s[SUM_W-1:FRAC_BITS]);
    fix = s[SUM_W-1] && (s[FRAC_BITS-1:0] != '0);
    r   = (SUM_W-FRAC_BITS+1)'(q) + $signed({{(SUM_W-FRAC_BITS){1'b0}}, fix});
    if (r > OUT_MAX) begin
      return OUT_W'(OUT_MAX);
    end else if (r < OUT_MIN) begin
      return OUT_W'(OUT_MIN);
    end
    return r[OUT_W-1:0];
  endfunction

endpackage

/* design/sapp_point_if.sv */
// ----------------------------------------------------------------------------
// sapp_point_if: input point channel
// Valid/ready channel carrying one 3D point per transfer.
// ----------------------------------------------------------------------------
interface sapp_point_if;
  logic                                        valid;
  logic                                        ready;
  logic signed [sapp_pkg::COORD_BITS-1:0]      point_x;
  logic signed [sapp_pkg::COORD_BITS-1:0]      point_y;
  logic signed [sapp_pkg::COORD_BITS-1:0]      point_z;

  modport source (output valid, output point_x, output point_y, output point_z,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z,
                  output ready);
endinterface

/* design/sapp_screen_if.sv */
// ----------------------------------------------------------------------------
// sapp_screen_if: output screen position channel
// Valid/ready channel carrying the red, blue and shared y screen positions.
// ----------------------------------------------------------------------------
interface sapp_screen_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [sapp_pkg::OUT_W-1:0]    red_x;
  logic signed [sapp_pkg::OUT_W-1:0]    blue_x;
  logic signed [sapp_pkg::OUT_W-1:0]    screen_y;

  modport source (output valid, output red_x, output blue_x, output screen_y,
                  input ready);
  modport sink   (input valid, input red_x, input blue_x, input screen_y,
                  output ready);
endinterface

/* design/sapp_rotate.sv */
// ----------------------------------------------------------------------------
// sapp_rotate: X then Y rotation, four pipeline stages
// Stage 1 forms the coordinate-angle products, stage 2 the X rotation,
// stage 3 the Y rotation products and stage 4 the floored Q.14 sums.
// ----------------------------------------------------------------------------
module sapp_rotate (
  input  logic                                   clk_i,
  input  logic [3:0]                             stage_en_i,
  input  sapp_pkg::cfg_t                         cfg_i,
  input  logic signed [sapp_pkg::COORD_BITS-1:0] x_i,
  input  logic signed [sapp_pkg::COORD_BITS-1:0] y_i,
  input  logic signed [sapp_pkg::COORD_BITS-1:0] z_i,
  output sapp_pkg::rot_t                         rot_o
);

  logic signed [sapp_pkg::PROD_W-1:0] ycx_q, zsx_q, ysx_q, zcx_q, xcy_q, xsy_q;
  logic signed [sapp_pkg::PROD_W-1:0] xcy2_q, xsy2_q, xcy3_q, xsy3_q;
  logic signed [sapp_pkg::ROT1_W-1:0] y1_q, z1_q, y1_3_q;
  logic signed [sapp_pkg::MUL2_W-1:0] z1sy_q, z1cy_q;
  logic signed [sapp_pkg::Q28_W-1:0]  sum_x_d, sum_z_d;
  sapp_pkg::rot_t                      rot_q;

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      ycx_q <= sapp_pkg::PROD_W'(y_i * cfg_i.cos_x);
      zsx_q <= sapp_pkg::PROD_W'(z_i * cfg_i.sin_x);
      ysx_q <= sapp_pkg::PROD_W'(y_i * cfg_i.sin_x);
      zcx_q <= sapp_pkg::PROD_W'(z_i * cfg_i.cos_x);
      xcy_q <= sapp_pkg::PROD_W'(x_i * cfg_i.cos_y);
      xsy_q <= sapp_pkg::PROD_W'(x_i * cfg_i.sin_y);
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      y1_q   <= sapp_pkg::ROT1_W'(ycx_q) - sapp_pkg::ROT1_W'(zsx_q);
      z1_q   <= sapp_pkg::ROT1_W'(ysx_q) + sapp_pkg::ROT1_W'(zcx_q);
      xcy2_q <= xcy_q;
      xsy2_q <= xsy_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[2]) begin
      z1sy_q <= sapp_pkg::MUL2_W'(z1_q * cfg_i.sin_y);
      z1cy_q <= sapp_pkg::MUL2_W'(z1_q * cfg_i.cos_y);
      xcy3_q <= xcy2_q;
      xsy3_q <= xsy2_q;
      y1_3_q <= y1_q;
    end
  end

  // x1 = x * 2^14, so x1 * angle is the stored product shifted up.
  always_comb begin
    sum_x_d = sapp_pkg::Q28_W'(z1sy_q)
            + (sapp_pkg::Q28_W'(xcy3_q) <<< sapp_pkg::FRAC_BITS);
    sum_z_d = sapp_pkg::Q28_W'(z1cy_q)
            - (sapp_pkg::Q28_W'(xsy3_q) <<< sapp_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[3]) begin
      rot_q.x2 <= sum_x_d[sapp_pkg::Q28_W-1:sapp_pkg::FRAC_BITS];
      rot_q.z2 <= sum_z_d[sapp_pkg::Q28_W-1:sapp_pkg::FRAC_BITS];
      rot_q.y1 <= y1_3_q;
    end
  end

  assign rot_o = rot_q;

endmodule

/* design/sapp_disparity.sv */
// ----------------------------------------------------------------------------
// sapp_disparity: depth disparity, two pipeline stages
// Stage 1 offsets z by the eye distance and takes the magnitude in pixels,
// stage 2 divides by five with a reciprocal multiply and clamps.
// ----------------------------------------------------------------------------
module sapp_disparity (
  input  logic            clk_i,
  input  logic [1:0]      stage_en_i,
  input  sapp_pkg::rot_t  rot_i,
  output sapp_pkg::disp_t disp_o
);

  logic signed [sapp_pkg::VSUM_W-1:0]                    v_d;
  logic [sapp_pkg::VSUM_W-1:0]                           mag_d;
  logic [sapp_pkg::VSUM_W-sapp_pkg::FRAC_BITS-1:0]       pix_d;
  logic                                                  neg_q, sat_q;
  logic [sapp_pkg::MAG_W-1:0]                            m_q;
  logic signed [sapp_pkg::ROT2_W-1:0]                    x2_q;
  logic signed [sapp_pkg::ROT1_W-1:0]                    y1_q;
  logic [sapp_pkg::MAG_W+15:0]                           prod_d;
  logic [sapp_pkg::DISP_MAG_W-1:0]                       qmag_d;
  logic signed [sapp_pkg::DISP_W-1:0]                    disp_d;
  sapp_pkg::disp_t                                       disp_q;

  always_comb begin
    v_d   = sapp_pkg::VSUM_W'(rot_i.z2) + sapp_pkg::EYE_DIST_Q14;
    mag_d = v_d[sapp_pkg::VSUM_W-1] ? sapp_pkg::VSUM_W'(-v_d) : sapp_pkg::VSUM_W'(v_d);
    pix_d = mag_d[sapp_pkg::VSUM_W-1:sapp_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      neg_q <= v_d[sapp_pkg::VSUM_W-1];
      sat_q <= (pix_d >= sapp_pkg::DISP_LIM);
      m_q   <= pix_d[sapp_pkg::MAG_W-1:0];
      x2_q  <= rot_i.x2;
      y1_q  <= rot_i.y1;
    end
  end

  // Below the clamp limit the quotient is exact with this reciprocal.
  always_comb begin
    prod_d = sapp_pkg::MAG_W'(m_q) * sapp_pkg::RECIP_5;
    qmag_d = sat_q ? sapp_pkg::DISP_MAG_W'(sapp_pkg::MAX_DISPARITY)
                   : prod_d[sapp_pkg::RECIP_SHIFT +: sapp_pkg::DISP_MAG_W];
    disp_d = neg_q ? -$signed({1'b0, qmag_d}) : $signed({1'b0, qmag_d});
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[1]) begin
      disp_q.x2   <= x2_q;
      disp_q.y1   <= y1_q;
      disp_q.disp <= disp_d;
    end
  end

  assign disp_o = disp_q;

endmodule

/* design/sapp_screen.sv */
// ----------------------------------------------------------------------------
// sapp_screen: screen coordinates, one pipeline stage
// Adds the eye and center offsets in Q.14, truncates toward zero and
// saturates into the output registers.
// ----------------------------------------------------------------------------
module sapp_screen (
  input  logic                              clk_i,
  input  logic                              stage_en_i,
  input  sapp_pkg::cfg_t                    cfg_i,
  input  sapp_pkg::disp_t                   disp_i,
  output logic signed [sapp_pkg::OUT_W-1:0] red_x_o,
  output logic signed [sapp_pkg::OUT_W-1:0] blue_x_o,
  output logic signed [sapp_pkg::OUT_W-1:0] screen_y_o
);

  logic signed [sapp_pkg::OFF_W-1:0] hw_d, hh_d, off_r_d, off_b_d;
  logic signed [sapp_pkg::SUM_W-1:0] sum_r_d, sum_b_d, sum_y_d;
  logic signed [sapp_pkg::OUT_W-1:0] red_q, blue_q, y_q;

  always_comb begin
    hw_d    = $signed({2'b00, cfg_i.half_w});
    hh_d    = $signed({2'b00, cfg_i.half_h});
    off_r_d = hw_d + sapp_pkg::OFF_W'(disp_i.disp);
    off_b_d = hw_d - sapp_pkg::OFF_W'(disp_i.disp);
    sum_r_d = sapp_pkg::SUM_W'(disp_i.x2)
            + (sapp_pkg::SUM_W'(off_r_d) <<< sapp_pkg::FRAC_BITS);
    sum_b_d = sapp_pkg::SUM_W'(disp_i.x2)
            + (sapp_pkg::SUM_W'(off_b_d) <<< sapp_pkg::FRAC_BITS);
    sum_y_d = sapp_pkg::SUM_W'(disp_i.y1)
            + (sapp_pkg::SUM_W'(hh_d) <<< sapp_pkg::FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i) begin
      red_q  <= sapp_pkg::trunc_sat(sum_r_d);
      blue_q <= sapp_pkg::trunc_sat(sum_b_d);
      y_q    <= sapp_pkg::trunc_sat(sum_y_d);
    end
  end

  assign red_x_o    = red_q;
  assign blue_x_o   = blue_q;
  assign screen_y_o = y_q;

endmodule

/* design/stereo_anaglyph_point_projection_core.sv */
// ----------------------------------------------------------------------------
// stereo_anaglyph_point_projection_core: stereo point projection pipeline
// Rotates a 3D point about X then Y and projects it to red and blue screen
// x positions split by a depth disparity, plus a shared screen y.
// ----------------------------------------------------------------------------
// Usage:
//   point_i carries one point (point_x, point_y, point_z) per transfer and
//   screen_o returns exactly one (red_x, blue_x, screen_y) per point, in
//   order. The configuration port writes the rotation sines and cosines
//   (Q1.14) and the screen center offsets; write it only while the pipeline
//   is empty, typically once per frame. Unknown indexes are ignored.
//   A point reaches screen_o through the seven register stages: four for
//   the rotation, two for the disparity divide and clamp, one for the
//   offset and saturation. Throughput is one point per cycle while
//   screen_o is ready. Each stage only loads when it is empty or the stage
//   after it moves, so bubbles close up and point_i keeps taking transfers
//   while a result waits on screen_o; ready on point_i only drops once all
//   seven stages hold a point behind a stalled receiver. Nothing is
//   dropped or repeated across a stall.
//   Reset clears every stage valid bit and loads identity rotation and a
//   400 by 300 screen center.
// ----------------------------------------------------------------------------
module stereo_anaglyph_point_projection_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sapp_point_if.sink                         point_i,
  sapp_screen_if.source                      screen_o,
  input  logic                               cfg_we_i,
  input  logic [sapp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sapp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int N = sapp_pkg::NUM_STAGES;

  sapp_pkg::cfg_t          cfg_q;
  logic [N-1:0]            valid_q;
  logic [N-1:0]            stage_en;
  sapp_pkg::rot_t          rot_w;
  sapp_pkg::disp_t         disp_w;

  // Configuration registers. Writes to indexes past the list fall through.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sin_x  <= sapp_pkg::SIN_RST;
      cfg_q.cos_x  <= sapp_pkg::COS_RST;
      cfg_q.sin_y  <= sapp_pkg::SIN_RST;
      cfg_q.cos_y  <= sapp_pkg::COS_RST;
      cfg_q.half_w <= sapp_pkg::HALF_W_RST;
      cfg_q.half_h <= sapp_pkg::HALF_H_RST;
    end else if (cfg_we_i) begin
      case (sapp_pkg::cfg_idx_e'(cfg_idx_i))
        sapp_pkg::CFG_SIN_X:       cfg_q.sin_x  <= $signed(cfg_data_i);
        sapp_pkg::CFG_COS_X:       cfg_q.cos_x  <= $signed(cfg_data_i);
        sapp_pkg::CFG_SIN_Y:       cfg_q.sin_y  <= $signed(cfg_data_i);
        sapp_pkg::CFG_COS_Y:       cfg_q.cos_y  <= $signed(cfg_data_i);
        sapp_pkg::CFG_HALF_WIDTH:  cfg_q.half_w <= cfg_data_i[sapp_pkg::OFFS_W-1:0];
        sapp_pkg::CFG_HALF_HEIGHT: cfg_q.half_h <= cfg_data_i[sapp_pkg::OFFS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on this cycle. The
  // enable ripples back from the output so a stall only fills bubbles.
  always_comb begin
    stage_en[N-1] = !valid_q[N-1] || screen_o.ready;
    for (int k = N - 2; k >= 0; k--) begin
      stage_en[k] = !valid_q[k] || stage_en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (stage_en[0]) begin
        valid_q[0] <= point_i.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (stage_en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  assign point_i.ready  = stage_en[0];
  assign screen_o.valid = valid_q[N-1];

  sapp_rotate u_rotate (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[3:0]),
    .cfg_i      (cfg_q),
    .x_i        (point_i.point_x),
    .y_i        (point_i.point_y),
    .z_i        (point_i.point_z),
    .rot_o      (rot_w)
  );

  sapp_disparity u_disparity (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[5:4]),
    .rot_i      (rot_w),
    .disp_o     (disp_w)
  );

  sapp_screen u_screen (
    .clk_i      (clk_i),
    .stage_en_i (stage_en[6]),
    .cfg_i      (cfg_q),
    .disp_i     (disp_w),
    .red_x_o    (screen_o.red_x),
    .blue_x_o   (screen_o.blue_x),
    .screen_y_o (screen_o.screen_y)
  );

  // Input back-pressure only appears when every stage is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !point_i.ready |-> (&valid_q))
    else $error("input stalled while the pipeline has a free stage");

  // An accepted point always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (point_i.valid && point_i.ready) |=> valid_q[0])
    else $error("accepted point was not captured");

  // The disparity handed to the output stage stays within the clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[5] |-> (disp_w.disp <= sapp_pkg::MAX_DISPARITY &&
                    disp_w.disp >= -sapp_pkg::MAX_DISPARITY))
    else $error("disparity outside the clamp range");

endmodule

/* verif/sapp_projection_checker.sv */
// ----------------------------------------------------------------------------
// sapp_projection_checker: scoreboard for the stereo point projection
// Watches the point and screen channels and the register port, computes the
// expected screen positions of every accepted point and compares each result
// in order, field by field.
// ----------------------------------------------------------------------------
module sapp_projection_checker
  import sapp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sapp_point_if                 point_mon,
  sapp_screen_if                screen_mon,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam longint UNIT_Q14     = longint'(1) << FRAC_BITS;
  localparam longint EYE_SPACING  = 1000;

  typedef struct packed {
    logic signed [OUT_W-1:0] red_x;
    logic signed [OUT_W-1:0] blue_x;
    logic signed [OUT_W-1:0] screen_y;
  } screen_t;

  cfg_t    view_q;
  screen_t screen_q[$];
  int      mismatches = 0;
  int      waiting    = 0;
  int      results    = 0;

  assign errors_o  = mismatches;
  assign pending_o = waiting;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("checker: result %0d %s: got %0d, expected %0d", results, what, got, want);
  endtask

  // Adds the integer offset to a Q.14 value, truncates toward zero and
  // saturates to the output range.
  function automatic logic signed [OUT_W-1:0] to_screen(input longint q14, input longint offset);
    longint whole;
    whole = (q14 + offset * UNIT_Q14) / UNIT_Q14;
    if (whole > OUT_MAX) begin
      whole = OUT_MAX;
    end else if (whole < OUT_MIN) begin
      whole = OUT_MIN;
    end
    return whole[OUT_W-1:0];
  endfunction

  function automatic screen_t project_point(input logic signed [COORD_BITS-1:0] px, py, pz);
    longint  sx, cx, sy, cy, hw, hh;
    longint  x1, y1, z1, x2, z2, disp;
    screen_t s;
    sx = longint'($signed(view_q.sin_x));
    cx = longint'($signed(view_q.cos_x));
    sy = longint'($signed(view_q.sin_y));
    cy = longint'($signed(view_q.cos_y));
    hw = longint'(view_q.half_w);
    hh = longint'(view_q.half_h);
    // Rotation about X is exact in Q.14; the Y rotation drops back from Q.28
    // to Q.14 by flooring, which the arithmetic shift gives.
    x1 = longint'(px) * UNIT_Q14;
    y1 = longint'(py) * cx - longint'(pz) * sx;
    z1 = longint'(py) * sx + longint'(pz) * cx;
    x2 = (z1 * sy + x1 * cy) >>> FRAC_BITS;
    z2 = (z1 * cy - x1 * sy) >>> FRAC_BITS;
    disp = (z2 + EYE_SPACING * UNIT_Q14) / (DISP_DIVISOR * UNIT_Q14);
    if (disp > MAX_DISPARITY) begin
      disp = MAX_DISPARITY;
    end else if (disp < -MAX_DISPARITY) begin
      disp = -MAX_DISPARITY;
    end
    s.red_x    = to_screen(x2, hw + disp);
    s.blue_x   = to_screen(x2, hw - disp);
    s.screen_y = to_screen(y1, hh);
    return s;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    screen_t want;
    if (!rst_ni) begin
      view_q = '{sin_x: SIN_RST, cos_x: COS_RST, sin_y: SIN_RST, cos_y: COS_RST,
                 half_w: HALF_W_RST, half_h: HALF_H_RST};
      screen_q.delete();
    end else begin
      if (screen_mon.valid && screen_mon.ready) begin
        results++;
        if (screen_q.size() == 0) begin
          report_mismatch("arrived with nothing expected, red_x", screen_mon.red_x, 0);
        end else begin
          want = screen_q.pop_front();
          if (screen_mon.red_x !== want.red_x) begin
            report_mismatch("red_x", screen_mon.red_x, want.red_x);
          end
          if (screen_mon.blue_x !== want.blue_x) begin
            report_mismatch("blue_x", screen_mon.blue_x, want.blue_x);
          end
          if (screen_mon.screen_y !== want.screen_y) begin
            report_mismatch("screen_y", screen_mon.screen_y, want.screen_y);
          end
        end
      end
      if (point_mon.valid && point_mon.ready) begin
        screen_q.push_back(project_point(point_mon.point_x, point_mon.point_y,
                                         point_mon.point_z));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIN_X:       view_q.sin_x  = cfg_data_i;
          CFG_COS_X:       view_q.cos_x  = cfg_data_i;
          CFG_SIN_Y:       view_q.sin_y  = cfg_data_i;
          CFG_COS_Y:       view_q.cos_y  = cfg_data_i;
          CFG_HALF_WIDTH:  view_q.half_w = cfg_data_i[OFFS_W-1:0];
          CFG_HALF_HEIGHT: view_q.half_h = cfg_data_i[OFFS_W-1:0];
          default: ;
        endcase
      end
    end
    waiting = screen_q.size();
  end

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the stereo point projection core
// Drives points through the core under a series of rotation and screen
// settings, with random gaps on both channels and a long receiver stall,
// while a checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
  import sapp_pkg::*;

  // A receiver hold-off of this length fills all seven stages and stalls
  // the point channel for most of its span.
  localparam int HOLD_OFF_CYCLES  = 160;
  // Cycles without any transfer before the run is declared hung. The
  // longest quiet stretch in a correct run is the hold-off above.
  localparam int QUIET_LIMIT      = 2000;
  localparam int RANDOM_PHASES    = 10;
  localparam int POINTS_PER_PHASE = 163;
  // Margin after the last result, derived from the pipeline depth.
  localparam int DRAIN_CYCLES     = 2 * NUM_STAGES;
  // Register indexes that decode to nothing; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  bit                    sender_burst;
  bit                    receiver_burst;

  sapp_point_if  point_bus ();
  sapp_screen_if screen_bus ();

  stereo_anaglyph_point_projection_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .point_i    (point_bus),
    .screen_o   (screen_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  sapp_projection_checker scoreboard (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .point_mon  (point_bus),
    .screen_mon (screen_bus),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // All inputs change on the falling edge, so the core and the checker see
  // stable values at every rising edge.

  // Offers one point after a random gap and returns at the rising edge of
  // its transfer. Valid stays high across back-to-back points; it is only
  // lowered when a gap follows.
  task automatic send_point(input logic signed [COORD_BITS-1:0] px, py, pz);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      point_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    point_bus.valid   <= 1'b1;
    point_bus.point_x <= px;
    point_bus.point_y <= py;
    point_bus.point_z <= pz;
    do @(posedge clk); while (!point_bus.ready);
  endtask

  // Stops offering points and waits until every expected result is back,
  // which leaves the pipeline empty and safe for register writes.
  task automatic drain_points();
    @(negedge clk);
    point_bus.valid <= 1'b0;
    wait (pending == 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  // Writes the complete view setting, then one write to a spare index that
  // must leave it unchanged.
  task automatic load_view(input logic [CFG_DATA_W-1:0] sx, cx, sy, cy, hw, hh);
    write_reg(CFG_SIN_X, sx);
    write_reg(CFG_COS_X, cx);
    write_reg(CFG_SIN_Y, sy);
    write_reg(CFG_COS_Y, cy);
    write_reg(CFG_HALF_WIDTH, hw);
    write_reg(CFG_HALF_HEIGHT, hh);
    write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Sines and cosines: mostly inside the Q1.14 range, sometimes the corner
  // values, sometimes any bit pattern at all, which the core must take as
  // a plain two's complement number.
  function automatic logic [CFG_DATA_W-1:0] pick_angle();
    logic [CFG_DATA_W-1:0] corners [5];
    int                    roll;
    corners = '{16'h8000, 16'h7FFF, 16'h4000, 16'hC000, 16'h0000};
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      return corners[$urandom_range(0, 4)];
    end
    if (roll < 7) begin
      return CFG_DATA_W'($urandom_range(0, 32768) - 16384);
    end
    return CFG_DATA_W'($urandom);
  endfunction

  // Screen offsets carry random junk above bit 12, which the core must drop.
  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    logic [OFFS_W-1:0] value;
    int                roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      value = '0;
    end else if (roll < 4) begin
      value = '1;
    end else begin
      value = OFFS_W'($urandom);
    end
    return {(CFG_DATA_W - OFFS_W)'($urandom), value};
  endfunction

  // Coordinates: full range most of the time, a band near the origin so the
  // disparity often stays clear of its clamp, and the extremes.
  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    logic signed [COORD_BITS-1:0] corners [4];
    int                           roll;
    corners = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};
    roll = $urandom_range(0, 19);
    if (roll < 3) begin
      return corners[$urandom_range(0, 3)];
    end
    if (roll < 9) begin
      return COORD_BITS'(int'($urandom_range(0, 4000)) - 2000);
    end
    return COORD_BITS'($urandom);
  endfunction

  // Result side: a random wait before each transfer, stretches with no wait
  // at all, and now and then one long hold-off while the sender keeps going.
  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    screen_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 32 == 0) begin
        receiver_burst = ($urandom_range(0, 3) == 0);
      end
      if (taken % 1000 == 250) begin
        stall = HOLD_OFF_CYCLES;
      end else if (receiver_burst) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 4);
      end
      @(negedge clk);
      if (stall > 0) begin
        screen_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      screen_bus.ready <= 1'b1;
      do @(posedge clk); while (!screen_bus.valid);
      taken++;
    end
  end

  // A hang on either channel shows up as a long run of cycles with no
  // transfer anywhere.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((point_bus.valid && point_bus.ready) || (screen_bus.valid && screen_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("testbench: done, errors");
    $finish;
  end

  initial begin : point_source
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    point_bus.valid   = 1'b0;
    point_bus.point_x = '0;
    point_bus.point_y = '0;
    point_bus.point_z = '0;
    sender_burst      = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset setting: identity rotation and a 400 by 300 center, so the
    // first points check the reset values of every register.
    send_point(16'sd0, 16'sd0, 16'sd0);
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd32767, -16'sd32768, 16'sd0);
    send_point(-16'sd32768, 16'sd32767, -16'sd1);
    // Depth just behind the eye plane: the disparity quotient is -0.8,
    // which must truncate to zero rather than floor to -1.
    send_point(16'sd5, -16'sd7, -16'sd1004);
    // Disparity one past the negative clamp, exactly on it, and exactly on
    // the positive clamp.
    send_point(-16'sd3, 16'sd9, -16'sd1355);
    send_point(16'sd100, -16'sd100, -16'sd1350);
    send_point(16'sd0, 16'sd0, -16'sd650);

    // Every register out of its nominal range: sines and cosines at the
    // two's complement extremes, a half width with junk in the upper data
    // bits, a zero half height with junk too. These points drive the
    // outputs into saturation in both directions.
    drain_points();
    load_view(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hE000);
    send_point(16'sd32767, 16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768, -16'sd32768);
    send_point(16'sd32767, -16'sd32768, 16'sd32767);
    send_point(-16'sd32768, 16'sd32767, -16'sd32768);
    send_point(16'sd1, -16'sd1, 16'sd1);
    send_point(-16'sd1, 16'sd1, -16'sd1);

    // A real view: 45 degrees about X, -30 degrees about Y, offsets at zero
    // and full scale. Small negative coordinates give negative fractions
    // that must truncate toward zero.
    drain_points();
    load_view(16'h2D41, 16'h2D41, 16'hE000, 16'h376D, 16'h0000, 16'h1FFF);
    send_point(16'sd3, 16'sd5, 16'sd7);
    send_point(-16'sd3, -16'sd5, -16'sd7);
    send_point(16'sd1, 16'sd0, 16'sd0);
    send_point(-16'sd1, 16'sd0, 16'sd0);
    send_point(16'sd0, 16'sd1, 16'sd1);
    send_point(16'sd1000, -16'sd1000, 16'sd500);
    send_point(-16'sd777, 16'sd333, -16'sd4000);

    // Random views, each followed by a block of random points. The sender
    // switches between idling and back-to-back stretches.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_points();
      load_view(pick_angle(), pick_angle(), pick_angle(), pick_angle(),
                pick_offset(), pick_offset());
      for (int i = 0; i < POINTS_PER_PHASE; i++) begin
        if (i % 32 == 0) begin
          sender_burst = ($urandom_range(0, 2) == 0);
        end
        send_point(pick_coord(), pick_coord(), pick_coord());
      end
    end

    drain_points();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
